// ===== rtl/core/dpsh_pkg.sv =====
package dpsh_pkg;

	localparam int HW = 30;
	localparam int PW = 60;

	// Capacity of the character store.
	localparam int MAX_LENGTH = 1024;

	typedef enum logic [1:0] {
		REQ_START  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_QUERY  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [1:0] CFG_BASE_A = 2'd0;
	localparam logic [1:0] CFG_MOD_A = 2'd1;
	localparam logic [1:0] CFG_BASE_B = 2'd2;
	localparam logic [1:0] CFG_MOD_B = 2'd3;

	localparam logic [29:0] RST_BASE_A = 30'd131;
	localparam logic [29:0] RST_MOD_A = 30'd1000000007;
	localparam logic [29:0] RST_BASE_B = 30'd13331;
	localparam logic [29:0] RST_MOD_B = 30'd998244353;

	// Command from the front end to the back end.
	typedef struct packed {
		req_t        kind;
		logic [15:0] char_code;
		logic [9:0]  left;
		logic [9:0]  right;
	} cmd_t;

endpackage

// ===== rtl/core/dpsh_ram.sv =====
module dpsh_ram #(
	parameter int WIDTH = 60,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/dpsh_modmul.sv =====
// Serial modular multiply-accumulate: (x * y + c) mod m.
// The first 16 steps reduce c by m, one bit of c per cycle; the next 30 steps multiply,
// one bit of y per cycle, most significant bit first. x is already below m; m is nonzero.
module dpsh_modmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [29:0] x,
	input  logic [29:0] y,
	input  logic [15:0] c,
	input  logic [29:0] m,
	output logic        done,
	output logic [29:0] res
);

	logic [29:0] acc_q, x_q, y_q, m_q, cr_q;
	logic [15:0] c_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        c_phase, bit_in;
	logic [29:0] addend;
	logic [31:0] dbl, dred, add, ared, sum, sred;

	always_comb begin
		c_phase = (cnt_q < 6'd16);
		bit_in = c_phase ? c_q[15] : y_q[29];
		addend = c_phase ? 30'd1 : x_q;
		dbl = {1'b0, acc_q, 1'b0};
		dred = (dbl >= {2'b0, m_q}) ? dbl - {2'b0, m_q} : dbl;
		add = dred + (bit_in ? {2'b0, addend} : 32'd0);
		ared = (add >= {2'b0, m_q}) ? add - {2'b0, m_q} : add;
		sum = {2'b0, acc_q} + {2'b0, cr_q};
		sred = (sum >= {2'b0, m_q}) ? sum - {2'b0, m_q} : sum;
	end

	assign res = sred[29:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd45) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q <= x;
			y_q <= y;
			c_q <= c;
			m_q <= m;
		end else if (busy_q) begin
			if (c_phase) begin
				c_q <= {c_q[14:0], 1'b0};
				// The reduced addend is parked and the accumulator restarts for the product.
				if (cnt_q == 6'd15) begin
					cr_q <= ared[29:0];
					acc_q <= '0;
				end else begin
					acc_q <= ared[29:0];
				end
			end else begin
				acc_q <= ared[29:0];
				y_q <= {y_q[28:0], 1'b0};
			end
		end
	end

endmodule

// ===== rtl/core/dpsh_front.sv =====
module dpsh_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [39:0]      s_tdata,
	output logic             q_valid,
	input  logic             q_ready,
	output dpsh_pkg::cmd_t   q_cmd
);
	import dpsh_pkg::*;

	cmd_t buf_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	cmd_t in_cmd;
	logic push, pop;

	always_comb begin
		in_cmd.kind = req_t'(s_tdata[1:0]);
		in_cmd.char_code = s_tdata[17:2];
		in_cmd.left = s_tdata[27:18];
		in_cmd.right = s_tdata[37:28];
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push = s_tvalid && s_tready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_cmd = buf_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= in_cmd;
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("command queue count out of range");

endmodule

// ===== rtl/core/dpsh_back.sv =====
module dpsh_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  dpsh_pkg::cmd_t q_cmd,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_addr,
	input  logic [29:0]    cfg_data,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [135:0]   m_tdata
);
	import dpsh_pkg::*;

	localparam int AW = $clog2(MAX_LENGTH + 1);
	localparam int LW = $clog2(MAX_LENGTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_APP_MUL, S_APP_WR, S_Q_RD1, S_Q_RD2, S_Q_MUL, S_Q_DIFF,
		S_SUF_INIT, S_SUF_RD, S_SUF_MUL, S_SUF_WR, S_OUT
	} st_t;

	st_t st_q;
	logic [29:0] base_a_q, mod_a_q, base_b_q, mod_b_q;
	logic [LW-1:0] len_q, idx_q;
	logic suf_ok_q;
	cmd_t cmd_q;
	logic [1:0] status_q;
	logic [59:0] fwd_q, rev_q;
	logic [59:0] hr_q, hl_q, sl_q, sr_q, pw_q;
	logic [59:0] nx_q;
	logic [1:0] phase_q;

	logic [29:0] ma, mb;
	assign ma = (mod_a_q == '0) ? 30'd1 : mod_a_q;
	assign mb = (mod_b_q == '0) ? 30'd1 : mod_b_q;

	// memories
	logic ch_we, pr_we, pw_we, sf_we;
	logic [AW-1:0] ch_wa, pr_wa, pw_wa, sf_wa, ch_ra, pr_ra, pw_ra, sf_ra;
	logic [15:0] ch_wd, ch_rd;
	logic [59:0] pr_wd, pr_rd, pw_wd, pw_rd, sf_wd, sf_rd;

	dpsh_ram #(.WIDTH(16), .DEPTH(MAX_LENGTH + 1)) u_ch (.clk, .we(ch_we), .waddr(ch_wa),
		.wdata(ch_wd), .raddr(ch_ra), .rdata(ch_rd));
	dpsh_ram #(.WIDTH(60), .DEPTH(MAX_LENGTH + 1)) u_pr (.clk, .we(pr_we), .waddr(pr_wa),
		.wdata(pr_wd), .raddr(pr_ra), .rdata(pr_rd));
	dpsh_ram #(.WIDTH(60), .DEPTH(MAX_LENGTH + 1)) u_pw (.clk, .we(pw_we), .waddr(pw_wa),
		.wdata(pw_wd), .raddr(pw_ra), .rdata(pw_rd));
	dpsh_ram #(.WIDTH(60), .DEPTH(MAX_LENGTH + 1)) u_sf (.clk, .we(sf_we), .waddr(sf_wa),
		.wdata(sf_wd), .raddr(sf_ra), .rdata(sf_rd));

	// four modular multipliers: powers/left parts of A and B, prefix/right parts
	logic mstart, d0, d1, d2, d3;
	logic [29:0] x0, y0, x1, y1, x2, y2, x3, y3, r0, r1, r2, r3;
	logic [15:0] c0, c1, c2, c3;
	dpsh_modmul u_m0 (.clk, .arst_n, .start(mstart), .x(x0), .y(y0), .c(c0), .m(ma),
		.done(d0), .res(r0));
	dpsh_modmul u_m1 (.clk, .arst_n, .start(mstart), .x(x1), .y(y1), .c(c1), .m(mb),
		.done(d1), .res(r1));
	dpsh_modmul u_m2 (.clk, .arst_n, .start(mstart), .x(x2), .y(y2), .c(c2), .m(ma),
		.done(d2), .res(r2));
	dpsh_modmul u_m3 (.clk, .arst_n, .start(mstart), .x(x3), .y(y3), .c(c3), .m(mb),
		.done(d3), .res(r3));

	function automatic logic [29:0] red(input logic [29:0] v, input logic [29:0] m);
		// Stored values are already below m; this guards raw inputs.
		return (v >= m) ? v - m : v;
	endfunction

	function automatic logic [29:0] sub_mod(input logic [29:0] a, input logic [29:0] b,
		input logic [29:0] m);
		logic [30:0] s;
		s = {1'b0, a} + {1'b0, m} - {1'b0, b};
		return (s >= {1'b0, m}) ? s[29:0] - m : s[29:0];
	endfunction

	logic [15:0] cc;
	logic [29:0] one_a, one_b;
	assign cc = (st_q == S_SUF_MUL) ? ch_rd : cmd_q.char_code;
	assign one_a = (ma == 30'd1) ? 30'd0 : 30'd1;
	assign one_b = (mb == 30'd1) ? 30'd0 : 30'd1;

	// entry zero of the power table is fixed by the moduli, that of the prefix table is zero
	logic [59:0] pw_eff, pr_eff;
	logic pw_zero_q, pr_zero_q;
	assign pw_eff = pw_zero_q ? {one_a, one_b} : pw_rd;
	assign pr_eff = pr_zero_q ? 60'd0 : pr_rd;

	always_comb begin
		ch_we = 1'b0; pr_we = 1'b0; pw_we = 1'b0; sf_we = 1'b0;
		ch_wa = len_q[AW-1:0]; ch_wd = cmd_q.char_code;
		pr_wa = AW'(len_q + 1'b1); pr_wd = {r2, r3};
		pw_wa = AW'(len_q + 1'b1); pw_wd = {r0, r1};
		sf_wa = idx_q[AW-1:0]; sf_wd = {r2, r3};
		ch_ra = AW'(idx_q - 1'b1); pr_ra = len_q[AW-1:0]; pw_ra = len_q[AW-1:0];
		sf_ra = {1'b0, cmd_q.left};
		x0 = red(pw_eff[59:30], ma); y0 = base_a_q; c0 = '0;
		x1 = red(pw_eff[29:0], mb);  y1 = base_b_q; c1 = '0;
		x2 = red(pr_eff[59:30], ma); y2 = base_a_q; c2 = cc;
		x3 = red(pr_eff[29:0], mb);  y3 = base_b_q; c3 = cc;
		mstart = 1'b0;
		unique case (st_q)
			S_APP_MUL: mstart = (phase_q == 2'd0);
			S_APP_WR: begin
				ch_we = 1'b1; pr_we = 1'b1; pw_we = 1'b1;
			end
			S_Q_RD1: begin
				pr_ra = AW'({1'b0, cmd_q.right} + 1'b1);
				pw_ra = AW'({1'b0, cmd_q.right} - {1'b0, cmd_q.left} + 1'b1);
				sf_ra = {1'b0, cmd_q.left};
			end
			S_Q_RD2: begin
				pr_ra = {1'b0, cmd_q.left};
				sf_ra = AW'({1'b0, cmd_q.right} + 1'b1);
			end
			S_Q_MUL: begin
				// Operands are loaded in phase zero, so the multipliers start in phase one.
				mstart = (phase_q == 2'd1);
				x0 = hl_q[59:30]; y0 = pw_q[59:30]; x1 = hl_q[29:0]; y1 = pw_q[29:0];
				x2 = sr_q[59:30]; y2 = pw_q[59:30]; x3 = sr_q[29:0]; y3 = pw_q[29:0];
				c2 = '0; c3 = '0;
			end
			S_SUF_INIT: begin
				sf_we = 1'b1; sf_wd = '0;
			end
			S_SUF_MUL: begin
				mstart = (phase_q == 2'd0);
				x2 = nx_q[59:30]; x3 = nx_q[29:0];
			end
			S_SUF_WR: begin
				sf_we = 1'b1; sf_wa = AW'(idx_q - 1'b1);
			end
			default: ;
		endcase
	end

	assign q_ready = (st_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			base_a_q <= RST_BASE_A; mod_a_q <= RST_MOD_A;
			base_b_q <= RST_BASE_B; mod_b_q <= RST_MOD_B;
			len_q <= '0; idx_q <= '0; suf_ok_q <= 1'b0; m_tvalid <= 1'b0;
			phase_q <= '0; pw_zero_q <= 1'b0; pr_zero_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_BASE_A: base_a_q <= cfg_data;
					CFG_MOD_A: mod_a_q <= cfg_data;
					CFG_BASE_B: base_b_q <= cfg_data;
					CFG_MOD_B: mod_b_q <= cfg_data;
					default: ;
				endcase
				len_q <= '0; suf_ok_q <= 1'b0;
			end
			if (st_q == S_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (q_valid) begin
					cmd_q <= q_cmd; status_q <= ST_OK; fwd_q <= '0; rev_q <= '0;
					unique case (q_cmd.kind)
						REQ_START: begin
							len_q <= '0; suf_ok_q <= 1'b0; st_q <= S_OUT;
						end
						REQ_APPEND: begin
							if (len_q >= LW'(MAX_LENGTH)) begin
								status_q <= ST_FULL; st_q <= S_OUT;
							end else begin
								pw_zero_q <= (len_q == '0); pr_zero_q <= (len_q == '0);
								st_q <= S_RD;
							end
						end
						REQ_QUERY: begin
							if (q_cmd.left > q_cmd.right || {1'b0, q_cmd.right} >= len_q) begin
								status_q <= ST_RANGE; st_q <= S_OUT;
							end else if (!suf_ok_q) begin
								idx_q <= len_q; st_q <= S_SUF_INIT;
							end else st_q <= S_Q_RD1;
						end
						default: st_q <= S_OUT;
					endcase
				end
				S_RD: begin phase_q <= '0; st_q <= S_APP_MUL; end
				S_APP_MUL: begin
					phase_q <= 2'd1;
					if (d0 && d1 && d2 && d3) st_q <= S_APP_WR;
				end
				S_APP_WR: begin
					len_q <= len_q + 1'b1; suf_ok_q <= 1'b0; st_q <= S_OUT;
				end
				S_SUF_INIT: begin
					nx_q <= '0;
					if (idx_q == '0) begin suf_ok_q <= 1'b1; st_q <= S_Q_RD1; end
					else st_q <= S_SUF_RD;
				end
				S_SUF_RD: begin phase_q <= '0; st_q <= S_SUF_MUL; end
				S_SUF_MUL: begin
					phase_q <= 2'd1;
					if (d2 && d3) st_q <= S_SUF_WR;
				end
				S_SUF_WR: begin
					nx_q <= {r2, r3};
					idx_q <= idx_q - 1'b1;
					if (idx_q == LW'(1)) begin suf_ok_q <= 1'b1; st_q <= S_Q_RD1; end
					else st_q <= S_SUF_RD;
				end
				S_Q_RD1: begin pw_zero_q <= 1'b0; pr_zero_q <= 1'b0; st_q <= S_Q_RD2; end
				S_Q_RD2: begin
					hr_q <= pr_rd; pw_q <= pw_rd; sl_q <= sf_rd;
					pr_zero_q <= (cmd_q.left == '0);
					phase_q <= '0; st_q <= S_Q_MUL;
				end
				S_Q_MUL: begin
					if (phase_q == 2'd0) begin
						hl_q <= pr_zero_q ? 60'd0 : pr_rd; sr_q <= sf_rd; phase_q <= 2'd1;
					end else if (phase_q == 2'd1) begin
						phase_q <= 2'd2;
					end else if (d0 && d1 && d2 && d3) st_q <= S_Q_DIFF;
				end
				S_Q_DIFF: begin
					fwd_q <= {sub_mod(hr_q[59:30], r0, ma), sub_mod(hr_q[29:0], r1, mb)};
					rev_q <= {sub_mod(sl_q[59:30], r2, ma), sub_mod(sl_q[29:0], r3, mb)};
					st_q <= S_OUT;
				end
				S_OUT: if (!m_tvalid || m_tready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_OUT && (!m_tvalid || m_tready)) begin
			m_tdata <= {3'd0, len_q, rev_q, fwd_q, status_q};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) len_q <= LW'(MAX_LENGTH))
		else $error("length beyond store");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_APP_WR) |=> m_tvalid == $past(m_tvalid) || st_q == S_OUT)
		else $error("append did not go to output");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_Q_MUL) |-> suf_ok_q)
		else $error("query without suffix table");

endmodule

// ===== rtl/core/double_polynomial_substring_hash.sv =====
// Channel | Direction | Payload
// s_*     | in        | tdata: req_type[1:0] char_code[17:2] query_left[27:18] query_right[37:28]
// m_*     | out       | tdata: status[1:0] forward_hash[61:2] reverse_hash[121:62] len[132:122]
// cfg_*   | in        | index 0..3 base_a, modulus_a, base_b, modulus_b
// Start, unused codes, bad ranges and appends to a full store go straight to the output state;
// an append runs a 46-step serial modular multiply-accumulate.
// A query first rebuilds the suffix table, one stored character at a time, when it is stale
// after a change. A two-entry command queue decouples input.
// A waiting result holds the back end until it is taken; it then accepts the next command.
// Reset restores the default registers and an empty string; no clearing pass is needed.
module double_polynomial_substring_hash (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [39:0]   s_tdata,  // req_type, char_code, query_left, query_right
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [135:0]  m_tdata,  // status, forward_hash, reverse_hash, string_length
	input  logic          cfg_we,
	input  logic [1:0]    cfg_addr,
	input  logic [29:0]   cfg_data
);
	import dpsh_pkg::*;

	logic q_valid, q_ready;
	cmd_t q_cmd;

	dpsh_front u_front (.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.q_valid, .q_ready, .q_cmd);

	dpsh_back u_back (.clk, .arst_n, .q_valid, .q_ready, .q_cmd,
		.cfg_we, .cfg_addr, .cfg_data, .m_tvalid, .m_tready, .m_tdata);

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import dpsh_pkg::*;

	localparam int MAXLEN = 1024;
	localparam int STALL_LIMIT = 200000;

	typedef struct packed {
		logic [1:0]  status;
		logic [59:0] fwd;
		logic [59:0] rev;
		logic [10:0] len;
	} hash_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [39:0]  s_tdata = '0;  // req_type, char_code, query_left, query_right
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [135:0] m_tdata;  // status, forward_hash, reverse_hash, string_length
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_addr = '0;
	logic [29:0]  cfg_data = '0;

	logic [39:0]  pending_reqs[$];
	hash_result_t expected_hashes[$];
	int           errors = 0;
	bit           quiet = 1'b0;
	int           src_gap = 0;
	int           sink_gap = 0;
	int           stall_cycles = 0;

	// Shadow copy of the hashing state.
	logic [29:0]       sh_base_a, sh_mod_a, sh_base_b, sh_mod_b;
	logic [15:0]       sh_chars[MAXLEN];
	longint unsigned   sh_prefix[MAXLEN + 1];
	longint unsigned   sh_suffix[MAXLEN + 1];
	longint unsigned   sh_power[MAXLEN + 1];
	int                sh_len;
	bit                sh_suffix_ok;

	always #1 clk = ~clk;

	double_polynomial_substring_hash i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	function automatic longint unsigned eff_mod(logic [29:0] m);
		return (m == 0) ? 64'd1 : 64'(m);
	endfunction

	function automatic longint unsigned mul_add(longint unsigned x, longint unsigned b,
			longint unsigned c, longint unsigned m);
		return ((x % m) * b + c) % m;
	endfunction

	function automatic longint unsigned sub_mul(longint unsigned hi, longint unsigned lo,
			longint unsigned pw, longint unsigned m);
		longint unsigned t;
		t = ((lo % m) * (pw % m)) % m;
		return ((hi % m) + m - t) % m;
	endfunction

	function automatic longint unsigned join_ab(longint unsigned a, longint unsigned b);
		return ((a & 64'h3FFF_FFFF) << 30) | (b & 64'h3FFF_FFFF);
	endfunction

	function automatic void clear_string();
		sh_len = 0;
		sh_suffix_ok = 1'b0;
		sh_prefix[0] = 0;
		sh_power[0] = join_ab(1 % eff_mod(sh_mod_a), 1 % eff_mod(sh_mod_b));
	endfunction

	function automatic hash_result_t predict_hashes(req_t kind, logic [15:0] ch,
			logic [9:0] l, logic [9:0] r);
		hash_result_t res;
		longint unsigned ma, mb, pw, hl, hr, sl, sr, nx;
		int n;
		res = '0;
		ma = eff_mod(sh_mod_a);
		mb = eff_mod(sh_mod_b);
		case (kind)
			REQ_START: clear_string();
			REQ_APPEND: begin
				if (sh_len >= MAXLEN) begin
					res.status = ST_FULL;
				end else begin
					n = sh_len;
					sh_chars[n] = ch;
					sh_power[n + 1] = join_ab(mul_add(sh_power[n] >> 30, sh_base_a, 0, ma),
						mul_add(sh_power[n] & 64'h3FFF_FFFF, sh_base_b, 0, mb));
					sh_prefix[n + 1] = join_ab(mul_add(sh_prefix[n] >> 30, sh_base_a, ch, ma),
						mul_add(sh_prefix[n] & 64'h3FFF_FFFF, sh_base_b, ch, mb));
					sh_len = n + 1;
					sh_suffix_ok = 1'b0;
				end
			end
			REQ_QUERY: begin
				if (l > r || int'(r) >= sh_len) begin
					res.status = ST_RANGE;
				end else begin
					if (!sh_suffix_ok) begin
						sh_suffix[sh_len] = 0;
						for (int i = sh_len; i > 0; i--) begin
							nx = sh_suffix[i];
							sh_suffix[i - 1] = join_ab(
								mul_add(nx >> 30, sh_base_a, sh_chars[i - 1], ma),
								mul_add(nx & 64'h3FFF_FFFF, sh_base_b, sh_chars[i - 1], mb));
						end
						sh_suffix_ok = 1'b1;
					end
					pw = sh_power[r - l + 1];
					hr = sh_prefix[r + 1];
					hl = sh_prefix[l];
					sl = sh_suffix[l];
					sr = sh_suffix[r + 1];
					res.fwd = join_ab(sub_mul(hr >> 30, hl >> 30, pw >> 30, ma),
						sub_mul(hr & 64'h3FFF_FFFF, hl & 64'h3FFF_FFFF, pw & 64'h3FFF_FFFF, mb));
					res.rev = join_ab(sub_mul(sl >> 30, sr >> 30, pw >> 30, ma),
						sub_mul(sl & 64'h3FFF_FFFF, sr & 64'h3FFF_FFFF, pw & 64'h3FFF_FFFF, mb));
				end
			end
			default: ;
		endcase
		res.len = 11'(sh_len);
		return res;
	endfunction

	task automatic send_req(req_t kind, logic [15:0] ch, logic [9:0] l, logic [9:0] r);
		expected_hashes.push_back(predict_hashes(kind, ch, l, r));
		pending_reqs.push_back({2'b00, r, l, ch, kind});
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_hashes.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [29:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_BASE_A: sh_base_a = val;
			CFG_MOD_A:  sh_mod_a = val;
			CFG_BASE_B: sh_base_b = val;
			default:    sh_mod_b = val;
		endcase
		clear_string();
	endtask

	// Mostly short strings so that suffix rebuilds stay cheap.
	task automatic random_traffic(int count);
		int pick, l, r;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 4 || (sh_len >= 40 && pick < 12)) begin
				send_req(REQ_START, 16'($urandom), 10'($urandom), 10'($urandom));
			end else if (pick < 7) begin
				send_req(REQ_NONE, 16'($urandom), 10'($urandom), 10'($urandom));
			end else if (pick < 55 && sh_len < 48) begin
				send_req(REQ_APPEND, 16'($urandom), 10'($urandom), 10'($urandom));
			end else if (pick < 88 && sh_len > 0) begin
				l = $urandom_range(0, sh_len - 1);
				r = $urandom_range(l, sh_len - 1);
				send_req(REQ_QUERY, 16'($urandom), 10'(l), 10'(r));
			end else begin
				send_req(REQ_QUERY, 16'($urandom), 10'($urandom), 10'($urandom));
			end
		end
	endtask

	// Source side: holds the head item until its transfer completes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				void'(pending_reqs.pop_front());
			if (s_tvalid && !s_tready) begin
				// keep holding the current item
			end else if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				src_gap <= $urandom_range(0, 14);
				s_tvalid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_reqs[0];
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Sink side: random backpressure and comparison against the shadow state.
	always @(posedge clk or negedge arst_n) begin
		hash_result_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[1:0];
				got.fwd = m_tdata[61:2];
				got.rev = m_tdata[121:62];
				got.len = m_tdata[132:122];
				if (expected_hashes.size() == 0) begin
					$error("unexpected result transfer");
					errors++;
				end else begin
					want = expected_hashes.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						errors++;
					end
					if (got.fwd !== want.fwd) begin
						$error("forward_hash: expected %h, actual %h", want.fwd, got.fwd);
						errors++;
					end
					if (got.rev !== want.rev) begin
						$error("reverse_hash: expected %h, actual %h", want.rev, got.rev);
						errors++;
					end
					if (got.len !== want.len) begin
						$error("string_length: expected %0d, actual %0d", want.len, got.len);
						errors++;
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				sink_gap <= $urandom_range(0, 14);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with outstanding work but no transfer.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(pending_reqs.size() == 0 && expected_hashes.size() == 0))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		sh_base_a = RST_BASE_A;
		sh_mod_a = RST_MOD_A;
		sh_base_b = RST_BASE_B;
		sh_mod_b = RST_MOD_B;
		clear_string();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty string, unused code, extreme characters, range errors.
		send_req(REQ_QUERY, 16'h0, 10'd0, 10'd0);
		send_req(REQ_NONE, 16'hFFFF, 10'h3FF, 10'h3FF);
		send_req(REQ_APPEND, 16'h0000, 10'd0, 10'd0);
		send_req(REQ_APPEND, 16'hFFFF, 10'h3FF, 10'h3FF);
		send_req(REQ_APPEND, 16'h5A5A, 10'd0, 10'd0);
		send_req(REQ_APPEND, 16'hA5A5, 10'd0, 10'd0);
		send_req(REQ_QUERY, 16'h0, 10'd0, 10'd3);
		send_req(REQ_QUERY, 16'h0, 10'd1, 10'd1);
		send_req(REQ_QUERY, 16'h0, 10'd2, 10'd1);
		send_req(REQ_QUERY, 16'h0, 10'd0, 10'd4);
		send_req(REQ_QUERY, 16'h0, 10'h3FF, 10'h3FF);
		send_req(REQ_APPEND, 16'h1234, 10'd0, 10'd0);
		send_req(REQ_QUERY, 16'h0, 10'd1, 10'd4);
		send_req(REQ_START, 16'h0, 10'd0, 10'd0);
		send_req(REQ_QUERY, 16'h0, 10'd0, 10'd0);
		random_traffic(60);
		wait_drained();

		write_reg(CFG_BASE_A, 30'd2);
		write_reg(CFG_MOD_A, 30'h3FFF_FFFF);
		write_reg(CFG_BASE_B, 30'h3FFF_FFFF);
		write_reg(CFG_MOD_B, 30'd2);
		random_traffic(50);
		wait_drained();

		// A modulus of zero acts as one; the other hash keeps working.
		write_reg(CFG_MOD_A, 30'd0);
		write_reg(CFG_BASE_A, 30'h3FFF_FFFF);
		write_reg(CFG_MOD_B, 30'h3FFF_FFFF);
		write_reg(CFG_BASE_B, 30'd2);
		random_traffic(40);
		wait_drained();

		// Build a long string, then query across it and past its end.
		write_reg(CFG_MOD_A, 30'd1000000007);
		write_reg(CFG_MOD_B, 30'd0);
		for (int k = 0; k < 200; k++)
			send_req(REQ_APPEND, 16'($urandom), 10'($urandom), 10'($urandom));
		send_req(REQ_APPEND, 16'hFFFF, 10'd0, 10'd0);
		send_req(REQ_QUERY, 16'h0, 10'd0, 10'd200);
		send_req(REQ_QUERY, 16'h0, 10'h3FF, 10'h3FF);
		send_req(REQ_QUERY, 16'h0, 10'd17, 10'd150);
		send_req(REQ_START, 16'h0, 10'd0, 10'd0);
		wait_drained();

		write_reg(CFG_BASE_A, RST_BASE_A);
		write_reg(CFG_MOD_A, RST_MOD_A);
		write_reg(CFG_BASE_B, RST_BASE_B);
		write_reg(CFG_MOD_B, RST_MOD_B);
		random_traffic(80);
		wait_drained();

		quiet = 1'b1;
		random_traffic(50);
		wait_drained();

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
